// ===== src/mms_pkg.sv =====
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and constants of the music sequencer.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int unsigned Channels  = 8;
  localparam int unsigned MemWords  = 4096;
  localparam int unsigned MaxEvents = 63;

  localparam int unsigned ChW  = $clog2(Channels);
  localparam int unsigned CntW = $clog2(Channels + 1);
  localparam int unsigned AddrW = $clog2(MemWords);
  localparam int unsigned BudW  = $clog2(MaxEvents + 1);

  localparam logic [2:0] OpTick  = 3'd0;
  localparam logic [2:0] OpLoad  = 3'd1;
  localparam logic [2:0] OpStart = 3'd2;
  localparam logic [2:0] OpPlay  = 3'd3;
  localparam logic [2:0] OpStop  = 3'd4;

  localparam logic [2:0] RegEnable  = 3'd0;
  localparam logic [2:0] RegTempo   = 3'd1;
  localparam logic [2:0] RegLimit   = 3'd2;
  localparam logic [2:0] RegRestart = 3'd3;
  localparam logic [2:0] RegEnd     = 3'd4;
  localparam logic [2:0] RegInstr   = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic       clr_play;   // stop, clear song time, begin arming
    logic       stop;
    logic       tick_begin; // reset budget, channel index 0
    logic       next_chan;
    logic       rd_delay;   // issue delay read at pointer or channel start
    logic       rd_cmd;     // advance pointer, issue command read
    logic       arm_load;   // load armed channel from delay word
    logic       arm_next;
    logic       arm_done;
    logic       do_cmd;     // handle the command word
    logic       add_delay;  // add delay word to due time
    logic       rewind;     // start a rewind sweep
    logic       rw_load;    // load rewound channel from delay word
    logic       rw_next;
    logic       status;     // issue status result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic arm_ok;     // current arm index may be armed
    logic chan_last;  // channel index past the end or none playing
    logic chan_walk;  // current channel active
    logic due;        // song time at or past due
    logic budget_out;
    logic is_restart;
    logic is_end;
    logic rw_last;    // rewind index past the end
  } sts_t;

endpackage

// ===== src/multichannel_music_sequencer.sv =====
// ----------------------------------------------------------------------------
// multichannel_music_sequencer
// Per-channel event sequencer over a pattern memory.
// ----------------------------------------------------------------------------
// usage: raise start with op_i and its fields while busy is low; the
// command is taken at that edge. load, set start and stop finish in that
// cycle. play arms each channel in turn, reading each first delay word
// from the pattern memory port. a tick walks the channels, skipping the
// inactive ones; for a due channel each command word is read, waited
// for and handled, then its following delay word is read, waited for
// and added; an end word stops the channel, and a restart word on channel
// 0 rewinds every channel armed by the last play. the end-of-tick status
// is the final result and shows in the cycle in which busy drops.
// each result shows on the output ports for one cycle with strobe_o high
// and last_o marks the status. the receiver cannot stall; results are
// never held back. the single-port pattern memory sets the tick length.
// reset clears control, channel state and the registers to their defaults;
// the pattern memory is undefined until loaded.
// ----------------------------------------------------------------------------
module multichannel_music_sequencer
  import mms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [2:0]  op_i,
  input  logic [11:0] address_i,
  input  logic [15:0] data_i,
  input  logic [2:0]  channel_i,
  output logic        strobe_o,
  output logic        kind_o,
  output logic [2:0]  out_channel_o,
  output logic [6:0]  command_o,
  output logic [7:0]  argument_o,
  output logic [3:0]  playing_o,
  output logic        overrun_o,
  output logic        last_o
);

  logic        enable_q;
  logic [15:0] tempo_q;
  logic [3:0]  limit_q;
  logic [7:0]  restart_q, end_q;
  logic [6:0]  instr_q;
  ctl_t ctl;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      tempo_q   <= 16'd4096;
      limit_q   <= 4'd8;
      restart_q <= 8'd254;
      end_q     <= 8'd255;
      instr_q   <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegEnable:  enable_q  <= cfg_data_i[0];
        RegTempo:   tempo_q   <= cfg_data_i;
        RegLimit:   limit_q   <= cfg_data_i[3:0];
        RegRestart: restart_q <= cfg_data_i[7:0];
        RegEnd:     end_q     <= cfg_data_i[7:0];
        RegInstr:   instr_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  mms_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (op_i),
    .enable_i (enable_q),
    .sts_i    (sts),
    .ctl_o    (ctl),
    .busy_o   (busy)
  );

  mms_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .op_i              (op_i),
    .address_i         (address_i),
    .data_i            (data_i),
    .channel_i         (channel_i),
    .tempo_step_i      (tempo_q),
    .channel_limit_i   (limit_q),
    .restart_code_i    (restart_q),
    .end_code_i        (end_q),
    .instrument_code_i (instr_q),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .strobe_o          (strobe_o),
    .kind_o            (kind_o),
    .out_channel_o     (out_channel_o),
    .command_o         (command_o),
    .argument_o        (argument_o),
    .playing_o         (playing_o),
    .overrun_o         (overrun_o),
    .last_o            (last_o)
  );

endmodule

// ===== src/mms_ctrl.sv =====
// ----------------------------------------------------------------------------
// mms_ctrl
// Sequencer state machine for play, tick walk and rewind.
// ----------------------------------------------------------------------------
module mms_ctrl
  import mms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] op_i,
  input  logic       enable_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o,
  output logic       busy_o
);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SArmChk  = 4'd1;
  localparam logic [3:0] SArmRd   = 4'd2;
  localparam logic [3:0] SArmWr   = 4'd3;
  localparam logic [3:0] SChan    = 4'd4;
  localparam logic [3:0] SDue     = 4'd5;
  localparam logic [3:0] SCmdWait = 4'd6;
  localparam logic [3:0] SCmd     = 4'd7;
  localparam logic [3:0] SDlyWait = 4'd8;
  localparam logic [3:0] SDlyAdd  = 4'd9;
  localparam logic [3:0] SRwChk   = 4'd10;
  localparam logic [3:0] SRwWait  = 4'd11;
  localparam logic [3:0] SRwWr    = 4'd12;
  localparam logic [3:0] SStatus  = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          if (op_i == OpTick && enable_i) begin
            ctl_o.tick_begin = 1'b1;
            state_d = SChan;
          end else if (op_i == OpPlay && enable_i) begin
            ctl_o.clr_play = 1'b1;
            state_d = SArmChk;
          end else if (op_i == OpStop) begin
            ctl_o.stop = 1'b1;
          end
        end
      end
      SArmChk: begin
        if (sts_i.arm_ok) begin
          ctl_o.rd_delay = 1'b1;
          state_d = SArmRd;
        end else begin
          ctl_o.arm_done = 1'b1;
          state_d = SIdle;
        end
      end
      SArmRd: state_d = SArmWr;
      SArmWr: begin
        ctl_o.arm_load = 1'b1;
        ctl_o.arm_next = 1'b1;
        state_d = SArmChk;
      end
      SChan: begin
        if (sts_i.chan_last) begin
          state_d = SStatus;
        end else if (sts_i.chan_walk) begin
          state_d = SDue;
        end else begin
          ctl_o.next_chan = 1'b1;
        end
      end
      SDue: begin
        if (!sts_i.due) begin
          ctl_o.next_chan = 1'b1;
          state_d = SChan;
        end else if (sts_i.budget_out) begin
          state_d = SStatus;
        end else begin
          ctl_o.rd_cmd = 1'b1;
          state_d = SCmdWait;
        end
      end
      SCmdWait: state_d = SCmd;
      SCmd: begin
        ctl_o.do_cmd = 1'b1;
        if (sts_i.is_restart) begin
          ctl_o.rewind = 1'b1;
          state_d = SRwChk;
        end else if (sts_i.is_end) begin
          ctl_o.next_chan = 1'b1;
          state_d = SChan;
        end else begin
          ctl_o.rd_delay = 1'b1;
          state_d = SDlyWait;
        end
      end
      SDlyWait: state_d = SDlyAdd;
      SDlyAdd: begin
        ctl_o.add_delay = 1'b1;
        state_d = SDue;
      end
      SRwChk: begin
        if (sts_i.rw_last) begin
          state_d = SDue;
        end else begin
          ctl_o.rd_delay = 1'b1;
          state_d = SRwWait;
        end
      end
      SRwWait: state_d = SRwWr;
      SRwWr: begin
        ctl_o.rw_load = 1'b1;
        ctl_o.rw_next = 1'b1;
        state_d = SRwChk;
      end
      SStatus: begin
        ctl_o.status = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

// ===== src/mms_datapath.sv =====
// ----------------------------------------------------------------------------
// mms_datapath
// Pattern memory, channel state, song time and result registers.
// ----------------------------------------------------------------------------
module mms_datapath
  import mms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  op_i,
  input  logic [11:0] address_i,
  input  logic [15:0] data_i,
  input  logic [2:0]  channel_i,
  input  logic [15:0] tempo_step_i,
  input  logic [3:0]  channel_limit_i,
  input  logic [7:0]  restart_code_i,
  input  logic [7:0]  end_code_i,
  input  logic [6:0]  instrument_code_i,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  output logic        strobe_o,
  output logic        kind_o,
  output logic [2:0]  out_channel_o,
  output logic [6:0]  command_o,
  output logic [7:0]  argument_o,
  output logic [3:0]  playing_o,
  output logic        overrun_o,
  output logic        last_o
);

  logic [15:0] mem [MemWords];
  logic [15:0] rdata_q;

  logic [AddrW-1:0] start_q [Channels];
  logic [Channels-1:0] armed_q, active_q;
  logic [AddrW-1:0] ptr_q [Channels];
  logic [31:0] due_q [Channels];
  logic [8:0]  instr_q [Channels];
  logic [31:0] song_q;
  logic [CntW-1:0] playing_q, count_q;
  logic [CntW-1:0] idx_q;   // channel walk or arm index
  logic [CntW-1:0] rw_q;    // rewind index
  logic [BudW-1:0] budget_q;
  logic [AddrW-1:0] p_q;    // working pointer
  logic [31:0] v_q;         // working due time
  logic busy_arm_q;

  logic [ChW-1:0] ci, ri;
  logic [CntW-1:0] lim;
  logic [AddrW-1:0] p_inc, p_inc2, rd_addr;
  logic rd_en;
  logic [7:0] k, x;
  logic is_restart, is_end, emit;

  assign ci  = idx_q[ChW-1:0];
  assign ri  = rw_q[ChW-1:0];
  assign lim = (channel_limit_i > 4'(Channels)) ? CntW'(Channels) : CntW'(channel_limit_i);
  assign p_inc  = p_q + AddrW'(1);
  assign p_inc2 = p_q + AddrW'(2);
  assign k = rdata_q[15:8];
  assign x = rdata_q[7:0];
  assign is_restart = (k == restart_code_i) && (ci == '0);
  assign is_end     = (k == end_code_i);

  // command reads use the working pointer; arming reads the start of the arm index, rewinding that of the rewind index
  always_comb begin
    rd_en = 1'b0;
    rd_addr = p_q;
    if (ctl_i.rd_cmd) begin
      rd_en = 1'b1;
      rd_addr = p_inc;
    end else if (ctl_i.rd_delay) begin
      rd_en = 1'b1;
      if (ctl_i.do_cmd) begin
        rd_addr = p_q;       // pointer already past the command word
      end else if (busy_arm_q) begin
        rd_addr = start_q[ci];
      end else begin
        rd_addr = start_q[ri];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_arm_q <= 1'b0;
    end else if (ctl_i.clr_play) begin
      busy_arm_q <= 1'b1;
    end else if (ctl_i.arm_done) begin
      busy_arm_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i && op_i == OpLoad) begin
      mem[address_i[AddrW-1:0]] <= data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    emit = !k[7];
    if (k[6:0] == instrument_code_i && !k[7] && instr_q[ci] == {1'b0, x}) begin
      emit = 1'b0;
    end
  end

  assign sts_o.arm_ok     = (idx_q < lim) && armed_q[ci] && (idx_q < CntW'(Channels));
  assign sts_o.chan_last  = (playing_q == '0) || (idx_q >= count_q);
  assign sts_o.chan_walk  = active_q[ci];
  assign sts_o.due        = (song_q >= v_q);
  assign sts_o.budget_out = (budget_q == '0);
  assign sts_o.is_restart = is_restart;
  assign sts_o.is_end     = is_end;
  assign sts_o.rw_last    = (rw_q >= count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < Channels; j++) begin
        start_q[j] <= '0;
        ptr_q[j]   <= '0;
        due_q[j]   <= '0;
        instr_q[j] <= 9'd256;
      end
      armed_q   <= '0;
      active_q  <= '0;
      song_q    <= '0;
      playing_q <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      rw_q      <= '0;
      budget_q  <= '0;
      p_q       <= '0;
      v_q       <= '0;
      strobe_o  <= 1'b0;
      kind_o    <= 1'b0;
      out_channel_o <= '0;
      command_o <= '0;
      argument_o <= '0;
      playing_o <= '0;
      overrun_o <= 1'b0;
      last_o    <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      if (start_i && !busy_i && op_i == OpStart && 32'(channel_i) < Channels) begin
        start_q[channel_i[ChW-1:0]] <= address_i[AddrW-1:0];
        armed_q[channel_i[ChW-1:0]] <= 1'b1;
      end
      if (ctl_i.stop) begin
        count_q <= '0;
        playing_q <= '0;
      end
      if (ctl_i.clr_play) begin
        song_q <= '0;
        idx_q <= '0;
      end
      if (ctl_i.arm_load) begin
        ptr_q[ci]   <= start_q[ci];
        due_q[ci]   <= {8'd0, rdata_q, 8'd0};
        instr_q[ci] <= 9'd256;
      end
      if (ctl_i.arm_next) idx_q <= idx_q + CntW'(1);
      if (ctl_i.arm_done) begin
        for (int j = 0; j < Channels; j++) begin
          active_q[j] <= (CntW'(j) < idx_q);
        end
        count_q   <= idx_q;
        playing_q <= idx_q;
      end
      if (ctl_i.tick_begin) begin
        idx_q <= '0;
        budget_q <= BudW'(MaxEvents);
        p_q <= ptr_q[0];
        v_q <= due_q[0];
      end
      if (ctl_i.next_chan) begin
        // commit working pointer and load next channel
        ptr_q[ci] <= p_q;
        due_q[ci] <= v_q;
        idx_q <= idx_q + CntW'(1);
        if (idx_q + CntW'(1) < CntW'(Channels)) begin
          p_q <= ptr_q[ci + ChW'(1)];
          v_q <= due_q[ci + ChW'(1)];
        end
      end
      if (ctl_i.rd_cmd) begin
        budget_q <= budget_q - BudW'(1);
        p_q <= p_inc2;
      end
      if (ctl_i.do_cmd && !is_restart) begin
        if (is_end) begin
          if (playing_q != '0) playing_q <= playing_q - CntW'(1);
          active_q[ci] <= 1'b0;
        end else begin
          if (!k[7] && k[6:0] == instrument_code_i && instr_q[ci] != {1'b0, x}) begin
            instr_q[ci] <= {1'b0, x};
          end
          if (emit) begin
            strobe_o <= 1'b1;
            kind_o <= 1'b0;
            out_channel_o <= ci;
            command_o <= k[6:0];
            argument_o <= x;
            playing_o <= '0;
            overrun_o <= 1'b0;
            last_o <= 1'b0;
          end
        end
      end
      if (ctl_i.add_delay) v_q <= v_q + {8'd0, rdata_q, 8'd0};
      if (ctl_i.rewind) begin
        playing_q <= count_q;
        rw_q <= '0;
        song_q <= {24'd0, song_q[7:0]};
      end
      if (ctl_i.rw_load) begin
        ptr_q[ri] <= start_q[ri];
        due_q[ri] <= {8'd0, rdata_q, 8'd0};
        active_q[ri] <= 1'b1;
        if (ri == '0) begin
          p_q <= start_q[0];
          v_q <= {8'd0, rdata_q, 8'd0};
        end
      end
      if (ctl_i.rw_next) rw_q <= rw_q + CntW'(1);
      if (ctl_i.status) begin
        if (!sts_o.chan_last) begin
          ptr_q[ci] <= p_q;
          due_q[ci] <= v_q;
        end
        song_q <= song_q + {16'd0, tempo_step_i};
        strobe_o <= 1'b1;
        kind_o <= 1'b1;
        out_channel_o <= '0;
        command_o <= '0;
        argument_o <= '0;
        playing_o <= 4'(playing_q);
        overrun_o <= !sts_o.chan_last;
        last_o <= 1'b1;
      end
    end
  end

endmodule

// ===== verif/tb_multichannel_music_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multichannel_music_sequencer
// Drives load, channel start, play, stop, tick and unused commands with random gaps.
// A built-in sequencer predictor queues the command and status results of
// every enabled tick, and each strobed result is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb_multichannel_music_sequencer;
  import mms_pkg::*;

  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;
  localparam int unsigned StreamSpan = 32;   // words per channel stream slot
  localparam int unsigned NoiseBase  = 256;  // noise loads stay above streams
  localparam int unsigned IdleLimit  = 40000;
  localparam int unsigned TargetItems = 460;

  typedef struct packed {
    logic       kind;
    logic [2:0] chan;
    logic [6:0] cmd;
    logic [7:0] arg;
    logic [3:0] playing;
    logic       overrun;
    logic       last;
  } seq_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic [2:0]  op_i = '0;
  logic [11:0] address_i = '0;
  logic [15:0] data_i = '0;
  logic [2:0]  channel_i = '0;
  logic        strobe_o, kind_o, overrun_o, last_o;
  logic [2:0]  out_channel_o;
  logic [6:0]  command_o;
  logic [7:0]  argument_o;
  logic [3:0]  playing_o;

  multichannel_music_sequencer dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] pat_mem [MemWords];
  logic [11:0] ch_start [Channels];
  logic        ch_armed [Channels];
  logic [11:0] ch_ptr [Channels];
  logic        ch_active [Channels];
  logic [31:0] ch_due [Channels];
  logic [8:0]  ch_instr [Channels];
  logic [31:0] song_time;
  int unsigned playing_cnt, chan_cnt;
  logic        r_enable;
  logic [15:0] r_tempo;
  logic [3:0]  r_limit;
  logic [7:0]  r_restart, r_end;
  logic [6:0]  r_instr;

  seq_result_t expected_q[$];
  int unsigned items_sent, ticks_sent, overruns_seen;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle;

  function automatic logic [31:0] delay_at(logic [11:0] a);
    return {8'h00, pat_mem[a], 8'h00};
  endfunction

  function automatic void rewind_channels();
    playing_cnt = chan_cnt;
    for (int j = 0; j < chan_cnt && j < Channels; j++) begin
      ch_ptr[j] = ch_start[j];
      ch_due[j] = delay_at(ch_start[j]);
      ch_active[j] = 1'b1;
    end
  endfunction

  function automatic void push_result(logic kind, int ch, logic [7:0] k, logic [7:0] x,
                                      int unsigned pl, logic ov);
    seq_result_t r;
    r.kind = kind; r.chan = ch[2:0]; r.cmd = k[6:0]; r.arg = x;
    r.playing = pl[3:0]; r.overrun = ov; r.last = kind;
    expected_q.push_back(r);
  endfunction

  function automatic void tick_events();
    int unsigned budget;
    bit over, halt, emit;
    logic [11:0] p;
    logic [31:0] v;
    logic [7:0]  k, x;
    budget = MaxEvents; over = 0; halt = 0;
    if (playing_cnt != 0) begin
      for (int i = 0; i < chan_cnt && i < Channels && !halt; i++) begin
        if (!ch_active[i]) continue;
        p = ch_ptr[i];
        v = ch_due[i];
        while (song_time >= v) begin
          if (budget == 0) begin
            over = 1; halt = 1;
            break;
          end
          budget--;
          p = p + 12'd1;
          k = pat_mem[p][15:8];
          x = pat_mem[p][7:0];
          p = p + 12'd1;
          if (k == r_restart && i == 0) begin
            rewind_channels();
            p = ch_ptr[0];
            v = ch_due[0];
            song_time &= 32'hff;
            continue;
          end
          if (k == r_end) begin
            if (playing_cnt > 0) playing_cnt--;
            ch_active[i] = 1'b0;
            break;
          end
          emit = !k[7];
          if (k == {1'b0, r_instr}) begin
            if (ch_instr[i] == {1'b0, x}) emit = 0;
            else ch_instr[i] = {1'b0, x};
          end
          if (emit) push_result(1'b0, i, k, x, 0, 1'b0);
          v += delay_at(p);
        end
        ch_ptr[i] = p;
        ch_due[i] = v;
      end
    end
    song_time += {16'h0, r_tempo};
    if (over) overruns_seen++;
    push_result(1'b1, 0, 8'h00, 8'h00, playing_cnt, over);
  endfunction

  function automatic void predict_command(logic [2:0] op, logic [11:0] a, logic [15:0] d,
                                          logic [2:0] ch);
    int unsigned n, lim;
    case (op)
      OpTick: if (r_enable) tick_events();
      OpLoad: pat_mem[a] = d;
      OpStart: begin
        ch_start[ch] = a;
        ch_armed[ch] = 1'b1;
      end
      OpPlay: if (r_enable) begin
        lim = (r_limit > Channels) ? Channels : r_limit;
        song_time = 0;
        n = 0;
        while (n < lim && ch_armed[n]) begin
          ch_ptr[n] = ch_start[n];
          ch_due[n] = delay_at(ch_start[n]);
          ch_instr[n] = 9'd256;
          ch_active[n] = 1'b1;
          n++;
        end
        for (int j = n; j < Channels; j++) ch_active[j] = 1'b0;
        chan_cnt = n;
        playing_cnt = n;
      end
      OpStop: begin
        chan_cnt = 0;
        playing_cnt = 0;
      end
      default: ;
    endcase
  endfunction

  // leaves start high unless it inserts a random idle gap, so back-to-back transactions need no second assignment
  task automatic send_command(logic [2:0] op, logic [11:0] a = '0, logic [15:0] d = '0,
                              logic [2:0] ch = '0);
    start <= 1'b1;
    op_i <= op; address_i <= a; data_i <= d; channel_i <= ch;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_command(op, a, d, ch);
    items_sent++;
    if (op == OpTick) ticks_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain_results();
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegEnable:  r_enable = val[0];
      RegTempo:   r_tempo = val;
      RegLimit:   r_limit = val[3:0];
      RegRestart: r_restart = val[7:0];
      RegEnd:     r_end = val[7:0];
      RegInstr:   r_instr = val[6:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_delay();
    case ($urandom_range(0, 9))
      0: return 16'hffff;
      1: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 2));
    endcase
  endfunction

  function automatic logic [7:0] rand_opcode(int ch);
    case ($urandom_range(0, 9))
      0, 1, 2: return {1'b0, r_instr};
      3: return (ch == 0 && $urandom_range(0, 2) == 0) ? r_restart : 8'($urandom);
      4: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  // one well-formed stream per channel slot, closed by the current end code
  task automatic load_streams(int max_cmds);
    int a, n;
    logic [7:0] k;
    for (int ch = 0; ch < Channels; ch++) begin
      a = ch * StreamSpan;
      n = $urandom_range(0, max_cmds);
      send_command(OpLoad, 12'(a), rand_delay()); a++;
      for (int c = 0; c < n; c++) begin
        k = rand_opcode(ch);
        send_command(OpLoad, 12'(a), {k, 8'($urandom_range(0, 1) ? 1 : $urandom)}); a++;
        send_command(OpLoad, 12'(a), rand_delay()); a++;
      end
      send_command(OpLoad, 12'(a), {r_end, 8'($urandom)});
      send_command(OpStart, 12'(ch * StreamSpan), '0, 3'(ch));
    end
  endtask

  task automatic test_disabled();
    send_command(OpTick);
    send_command(OpPlay);
    send_command(OpStop);
    send_command(OpUnusedHi);
  endtask

  task automatic test_basic_stream();
    write_reg(RegEnable, 16'd1);
    // channel 0: repeated instrument, high-bit opcode, extreme argument
    send_command(OpLoad, 12'd0, 16'h0000);
    send_command(OpLoad, 12'd1, {1'b0, r_instr, 8'h05});
    send_command(OpLoad, 12'd2, 16'h0000);
    send_command(OpLoad, 12'd3, {1'b0, r_instr, 8'h05});
    send_command(OpLoad, 12'd4, 16'h0010);
    send_command(OpLoad, 12'd5, 16'h83aa);
    send_command(OpLoad, 12'd6, 16'h0000);
    send_command(OpLoad, 12'd7, 16'h7fff);
    send_command(OpLoad, 12'd8, 16'h0000);
    send_command(OpLoad, 12'd9, {r_end, 8'h00});
    // channel 1: restart code off channel zero acts as a plain opcode
    send_command(OpLoad, 12'd32, 16'h0000);
    send_command(OpLoad, 12'd33, {r_restart, 8'h11});
    send_command(OpLoad, 12'd34, 16'h0000);
    send_command(OpLoad, 12'd35, {r_end, 8'hff});
    send_command(OpStart, 12'd0, '0, 3'd0);
    send_command(OpStart, 12'd32, '0, 3'd1);
    send_command(OpPlay);
    repeat (3) send_command(OpTick);
  endtask

  task automatic test_overrun();
    // endless restart on channel zero spends the whole budget
    send_command(OpLoad, 12'd1, {r_restart, 8'h00});
    write_reg(RegTempo, 16'hffff);
    send_command(OpPlay);
    repeat (2) send_command(OpTick);
    write_reg(RegTempo, 16'h0000);
    send_command(OpTick);
  endtask

  task automatic test_channel_limit();
    write_reg(RegLimit, 16'd0);
    send_command(OpPlay);
    send_command(OpTick);
    write_reg(RegLimit, 16'd8);
    write_reg(RegTempo, 16'd4096);
  endtask

  task automatic test_random();
    int unsigned ticks;
    logic [7:0] code;
    while (items_sent < TargetItems) begin
      if (items_sent > TargetItems - 80) no_idle = 1;
      write_reg(RegEnable, ($urandom_range(0, 7) == 0) ? 16'd0 : 16'd1);
      case ($urandom_range(0, 3))
        0: write_reg(RegTempo, 16'hffff);
        1: write_reg(RegTempo, 16'($urandom_range(0, 65535)));
        default: write_reg(RegTempo, 16'($urandom_range(256, 8192)));
      endcase
      write_reg(RegLimit, 16'($urandom_range(0, 8)));
      code = 8'($urandom);
      write_reg(RegRestart, {8'h00, code});
      write_reg(RegEnd, ($urandom_range(0, 5) == 0) ? 16'(code) : 16'($urandom_range(0, 255)));
      write_reg(RegInstr, 16'($urandom_range(0, 127)));
      load_streams(3);
      send_command(OpPlay);
      ticks = $urandom_range(8, 24);
      for (int t = 0; t < ticks; t++) begin
        case ($urandom_range(0, 19))
          0: send_command(OpLoad, 12'($urandom_range(NoiseBase, MemWords - 1)), 16'($urandom));
          1: send_command(3'($urandom_range(OpUnusedLo, OpUnusedHi)), 12'($urandom),
                          16'($urandom), 3'($urandom));
          2: send_command(OpStart, 12'($urandom_range(0, Channels - 1) * StreamSpan), '0,
                          3'($urandom));
          3: send_command(OpPlay);
          4: if ($urandom_range(0, 2) == 0) send_command(OpStop);
          5: begin
            // hold off until the block has delivered everything
            start <= 1'b0;
            @(posedge clk_i);
            while (expected_q.size() != 0) @(posedge clk_i);
          end
          default: ;
        endcase
        send_command(OpTick);
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    seq_result_t exp_r, got;
    if (rst_ni && strobe_o) begin
      got = {kind_o, out_channel_o, command_o, argument_o, playing_o, overrun_o, last_o};
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result: kind %0d ch %0d cmd %h arg %h", kind_o,
                   out_channel_o, command_o, argument_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.kind !== exp_r.kind || got.chan !== exp_r.chan || got.cmd !== exp_r.cmd ||
            got.arg !== exp_r.arg || got.playing !== exp_r.playing ||
            got.overrun !== exp_r.overrun || got.last !== exp_r.last) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch: exp kind %0d ch %0d cmd %h arg %h play %0d ovr %0d last %0d,",
                      " got kind %0d ch %0d cmd %h arg %h play %0d ovr %0d last %0d"},
                     exp_r.kind, exp_r.chan, exp_r.cmd, exp_r.arg, exp_r.playing,
                     exp_r.overrun, exp_r.last, got.kind, got.chan, got.cmd, got.arg,
                     got.playing, got.overrun, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    items_sent = 0; ticks_sent = 0; overruns_seen = 0; no_idle = 0;
    for (int j = 0; j < Channels; j++) begin
      ch_start[j] = '0; ch_armed[j] = 0; ch_ptr[j] = '0; ch_active[j] = 0;
      ch_due[j] = '0; ch_instr[j] = 9'd256;
    end
    song_time = 0; playing_cnt = 0; chan_cnt = 0;
    r_enable = 0; r_tempo = 16'd4096; r_limit = 4'd8;
    r_restart = 8'd254; r_end = 8'd255; r_instr = 7'd1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled();
    test_basic_stream();
    test_overrun();
    test_channel_limit();
    test_random();
    drain_results();
    $display("sent %0d commands (%0d ticks), checked %0d results, %0d overrun ticks",
             items_sent, ticks_sent, results_seen, overruns_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, expected_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
